/* hw/rtl/wcs_pkg.sv */
`default_nettype none
package wcs_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int WEIGHT_W     = 16;
  localparam int Z_W          = 20;
  localparam int FIX_W        = 32;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int WSUM_W       = 39;
  localparam int WTOT_W       = 22;
  localparam int ACC_W        = 86;
  localparam int DEN_W        = 32;
  localparam int VAR_W        = 64;
  localparam int DIFF_W       = 34;
  localparam int DEF_MAX_ROWS = 64;

  localparam logic [CNT_W-1:0] MEAN_BITS = 7'd55;
  localparam logic [CNT_W-1:0] VAR_BITS  = 7'd86;
  localparam logic [CNT_W-1:0] Z_BITS    = 7'd46;

  localparam logic [Z_W-1:0] Z_POS_MAX = 20'h7FFFF;
  localparam logic [Z_W-1:0] Z_NEG_MIN = 20'h80000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [WEIGHT_W-1:0]        weight;
  } row_t;

  typedef struct packed {
    logic [CNT_W-1:0]         n;
    logic signed [WSUM_W-1:0] wsum;
    logic [WTOT_W-1:0]        wtot;
  } job_t;

endpackage
`default_nettype wire

/* hw/rtl/wcs_fifo.sv */
`default_nettype none
module wcs_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wcs_pkg::job_t      push_data,
  output logic               full,
  input  wire logic          pop,
  output wcs_pkg::job_t      pop_data,
  output logic               empty
);

  wcs_pkg::job_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push && !full) wr_ptr_r <= !wr_ptr_r;
      if (pop && !empty) rd_ptr_r <= !rd_ptr_r;
      if ((push && !full) && !(pop && !empty)) cnt_r <= cnt_r + 2'd1;
      else if (!(push && !full) && (pop && !empty)) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/wcs_div.sv */
`default_nettype none
module wcs_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [wcs_pkg::ACC_W-1:0]   num,
  input  wire logic [wcs_pkg::DEN_W-1:0]   den,
  input  wire logic [wcs_pkg::CNT_W-1:0]   nbits,
  output logic                             done,
  output logic [wcs_pkg::ACC_W-1:0]        quo
);

  logic [wcs_pkg::ACC_W-1:0] num_r, quo_r;
  logic [wcs_pkg::DEN_W-1:0] den_r, rem_r;
  logic [wcs_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r, done_r;
  logic [wcs_pkg::DEN_W:0]   trial, diff;
  logic                      ge;

  assign trial = {rem_r, num_r[wcs_pkg::ACC_W-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        quo_r  <= '0;
        cnt_r  <= nbits;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[wcs_pkg::DEN_W-1:0] : trial[wcs_pkg::DEN_W-1:0];
        quo_r <= {quo_r[wcs_pkg::ACC_W-2:0], ge};
        num_r <= {num_r[wcs_pkg::ACC_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/wcs_sqrt.sv */
`default_nettype none
module wcs_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [wcs_pkg::VAR_W-1:0]   val,
  output logic                             done,
  output logic [wcs_pkg::FIX_W-1:0]        root
);

  logic [wcs_pkg::VAR_W-1:0] v_r;
  logic [33:0]               r_r;
  logic [wcs_pkg::FIX_W-1:0] q_r;
  logic [5:0]                cnt_r;
  logic                      busy_r, done_r;
  logic [35:0]               tmp, trial, diff;
  logic                      ge;

  assign tmp   = {r_r, v_r[wcs_pkg::VAR_W-1 -: 2]};
  assign trial = {2'b00, q_r, 2'b01};
  assign ge    = (tmp >= trial);
  assign diff  = tmp - trial;
  assign done  = done_r;
  assign root  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= val;
        r_r    <= '0;
        q_r    <= '0;
        cnt_r  <= 6'd32;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        r_r   <= ge ? diff[33:0] : tmp[33:0];
        q_r   <= {q_r[wcs_pkg::FIX_W-2:0], ge};
        v_r   <= {v_r[wcs_pkg::VAR_W-3:0], 2'b00};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/wcs_front.sv */
`default_nettype none
module wcs_front #(
  parameter int MaxRows = wcs_pkg::DEF_MAX_ROWS,
  localparam int AddrW  = $clog2(MaxRows)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [wcs_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic [wcs_pkg::WEIGHT_W-1:0]        in_weight,
  input  wire logic                                in_last,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic                                cfg_use_weights,
  input  wire logic [AddrW-1:0]                    rd_addr,
  output wcs_pkg::row_t                            rd_row,
  output logic                                     job_push,
  output wcs_pkg::job_t                            job_data,
  input  wire logic                                job_full,
  input  wire logic                                back_done
);

  wcs_pkg::row_t mem [MaxRows];
  wcs_pkg::row_t rd_row_r;

  logic                               use_weights_r, busy_r;
  logic [wcs_pkg::CNT_W-1:0]          count_r;
  logic signed [wcs_pkg::WSUM_W-1:0]  wsum_r;
  logic [wcs_pkg::WTOT_W-1:0]         wtot_r;

  logic                               acc, stored;
  logic [wcs_pkg::WEIGHT_W-1:0]       w_eff;
  logic signed [32:0]                 prod;
  logic signed [wcs_pkg::WSUM_W-1:0]  wsum_nxt;
  logic [wcs_pkg::WTOT_W-1:0]         wtot_nxt;
  logic [wcs_pkg::CNT_W-1:0]          count_nxt;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy_r && !job_full;
  assign acc       = in_valid && in_ready;
  assign stored    = (count_r < wcs_pkg::CNT_W'(MaxRows));
  assign w_eff     = use_weights_r ? in_weight : wcs_pkg::WEIGHT_W'(1);
  assign prod      = in_sample * $signed({1'b0, w_eff});
  assign wsum_nxt  = stored ? wsum_r + wcs_pkg::WSUM_W'(prod) : wsum_r;
  assign wtot_nxt  = stored ? wtot_r + wcs_pkg::WTOT_W'(w_eff) : wtot_r;
  assign count_nxt = stored ? count_r + 1'b1 : count_r;

  assign job_push      = acc && in_last;
  assign job_data.n    = count_nxt;
  assign job_data.wsum = wsum_nxt;
  assign job_data.wtot = wtot_nxt;
  assign rd_row        = rd_row_r;

  always_ff @(posedge clk) begin
    if (acc && stored) begin
      mem[count_r[AddrW-1:0]] <= '{sample: in_sample, weight: w_eff};
    end
    rd_row_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_weights_r <= 1'b1;
      busy_r        <= 1'b0;
      count_r       <= '0;
      wsum_r        <= '0;
      wtot_r        <= '0;
    end else begin
      if (cfg_valid) use_weights_r <= cfg_use_weights;
      if (back_done) busy_r <= 1'b0;
      if (acc) begin
        if (in_last) begin
          busy_r  <= 1'b1;
          count_r <= '0;
          wsum_r  <= '0;
          wtot_r  <= '0;
        end else begin
          count_r <= count_nxt;
          wsum_r  <= wsum_nxt;
          wtot_r  <= wtot_nxt;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/wcs_back.sv */
`default_nettype none
module wcs_back #(
  parameter int MaxRows = wcs_pkg::DEF_MAX_ROWS,
  localparam int AddrW  = $clog2(MaxRows)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              job_empty,
  input  wcs_pkg::job_t                          job_data,
  output logic                                   job_pop,
  output logic [AddrW-1:0]                       rd_addr,
  input  wcs_pkg::row_t                          rd_row,
  output logic                                   back_done,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [wcs_pkg::Z_W-1:0]         out_standardized,
  output logic signed [wcs_pkg::FIX_W-1:0]       out_center,
  output logic [wcs_pkg::FIX_W-1:0]              out_spread,
  output logic [wcs_pkg::IDX_W-1:0]              out_row_index,
  output logic                                   out_error,
  output logic                                   out_final_res
);

  typedef enum logic [4:0] {
    S_IDLE, S_MGO, S_MWT, S_VRD, S_VD, S_VSQ, S_VW, S_VACC,
    S_VGO, S_VWT, S_SGO, S_SWT, S_ZRD, S_ZD, S_ZGO, S_ZWT, S_EMIT
  } state_t;

  state_t                             state_r;
  wcs_pkg::job_t                      job_r;
  logic [wcs_pkg::CNT_W-1:0]          i_r;
  logic signed [wcs_pkg::FIX_W-1:0]   mean_r;
  logic [wcs_pkg::FIX_W-1:0]          sd_r;
  logic                               err_r;
  logic [wcs_pkg::ACC_W-1:0]          acc_r;
  logic [wcs_pkg::FIX_W-1:0]          m_r;
  logic [wcs_pkg::WEIGHT_W-1:0]       w_r;
  logic [wcs_pkg::VAR_W-1:0]          p_r, var_r;
  logic [47:0]                        pl_r, ph_r;
  logic signed [wcs_pkg::DIFF_W-1:0]  d_r;
  logic [wcs_pkg::Z_W-1:0]            z_r;
  logic                               out_valid_r;
  logic [wcs_pkg::Z_W-1:0]            out_z_r;
  logic [wcs_pkg::FIX_W-1:0]          out_center_r, out_spread_r;
  logic [wcs_pkg::IDX_W-1:0]          out_row_r;
  logic                               out_err_r, out_fin_r;

  logic                               div_start, div_done, sq_start, sq_done;
  logic [wcs_pkg::ACC_W-1:0]          div_num, div_quo;
  logic [wcs_pkg::DEN_W-1:0]          div_den;
  logic [wcs_pkg::CNT_W-1:0]          div_bits;
  logic [wcs_pkg::FIX_W-1:0]          sq_root;
  logic [wcs_pkg::WSUM_W-1:0]         wsum_mag;
  logic [wcs_pkg::DIFF_W-1:0]         d_mag;
  logic signed [wcs_pkg::DIFF_W-1:0]  d_cur;
  logic [wcs_pkg::DIFF_W-1:0]         d_cur_mag;
  logic [wcs_pkg::FIX_W-1:0]          mean_q;
  logic [45:0]                        zq;
  logic                               can_emit, last_row;

  assign wsum_mag = job_r.wsum[wcs_pkg::WSUM_W-1] ? wcs_pkg::WSUM_W'(-job_r.wsum)
                                                  : wcs_pkg::WSUM_W'(job_r.wsum);
  assign d_mag     = d_r[wcs_pkg::DIFF_W-1] ? wcs_pkg::DIFF_W'(-d_r) : wcs_pkg::DIFF_W'(d_r);
  assign d_cur     = $signed({{2{rd_row.sample[wcs_pkg::SAMPLE_W-1]}}, rd_row.sample, 16'd0})
                   - $signed({{2{mean_r[wcs_pkg::FIX_W-1]}}, mean_r});
  assign d_cur_mag = d_cur[wcs_pkg::DIFF_W-1] ? wcs_pkg::DIFF_W'(-d_cur)
                                              : wcs_pkg::DIFF_W'(d_cur);
  assign mean_q    = div_quo[wcs_pkg::FIX_W-1:0];
  assign zq        = div_quo[45:0];
  assign rd_addr   = i_r[AddrW-1:0];
  assign job_pop   = (state_r == S_IDLE) && !job_empty;
  assign can_emit  = !out_valid_r || out_ready;
  assign last_row  = ((i_r + 1'b1) == job_r.n);
  assign back_done = (state_r == S_EMIT) && can_emit && last_row;
  assign out_valid = out_valid_r;
  assign div_start = (state_r == S_MGO) || (state_r == S_VGO) || (state_r == S_ZGO);
  assign sq_start  = (state_r == S_SGO);
  assign div_den   = (state_r == S_ZGO) ? sd_r : wcs_pkg::DEN_W'(job_r.wtot);

  assign out_standardized = out_z_r;
  assign out_center       = out_center_r;
  assign out_spread       = out_spread_r;
  assign out_row_index    = out_row_r;
  assign out_error        = out_err_r;
  assign out_final_res    = out_fin_r;

  always_comb begin
    div_num  = acc_r;
    div_bits = wcs_pkg::VAR_BITS;
    unique case (state_r)
      S_MGO: begin
        div_num  = {wsum_mag, 47'd0};
        div_bits = wcs_pkg::MEAN_BITS;
      end
      S_ZGO: begin
        div_num  = {d_mag, 52'd0};
        div_bits = wcs_pkg::Z_BITS;
      end
      default: ;
    endcase
  end

  wcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .nbits (div_bits),
    .done  (div_done),
    .quo   (div_quo)
  );

  wcs_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .val   (var_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
    end else begin
      if ((state_r == S_EMIT) && can_emit) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!job_empty) begin
            job_r <= job_data;
            i_r   <= '0;
            acc_r <= '0;
            if (job_data.wtot == '0) begin
              err_r   <= 1'b1;
              mean_r  <= '0;
              sd_r    <= '0;
              state_r <= S_ZRD;
            end else begin
              err_r   <= 1'b0;
              state_r <= S_MGO;
            end
          end
        end
        S_MGO: state_r <= S_MWT;
        S_MWT: begin
          if (div_done) begin
            mean_r  <= job_r.wsum[wcs_pkg::WSUM_W-1] ? $signed(-mean_q) : $signed(mean_q);
            state_r <= S_VRD;
          end
        end
        S_VRD: state_r <= S_VD;
        S_VD: begin
          m_r     <= d_cur_mag[wcs_pkg::FIX_W-1:0];
          w_r     <= rd_row.weight;
          state_r <= S_VSQ;
        end
        S_VSQ: begin
          p_r     <= m_r * m_r;
          state_r <= S_VW;
        end
        S_VW: begin
          pl_r    <= p_r[31:0] * w_r;
          ph_r    <= p_r[63:32] * w_r;
          state_r <= S_VACC;
        end
        S_VACC: begin
          acc_r <= acc_r + wcs_pkg::ACC_W'(pl_r) + wcs_pkg::ACC_W'({ph_r, 32'd0});
          if (last_row) begin
            i_r     <= '0;
            state_r <= S_VGO;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_VRD;
          end
        end
        S_VGO: state_r <= S_VWT;
        S_VWT: begin
          if (div_done) begin
            var_r   <= div_quo[wcs_pkg::VAR_W-1:0];
            state_r <= S_SGO;
          end
        end
        S_SGO: state_r <= S_SWT;
        S_SWT: begin
          if (sq_done) begin
            sd_r    <= sq_root;
            state_r <= S_ZRD;
          end
        end
        S_ZRD: state_r <= S_ZD;
        S_ZD: begin
          d_r <= d_cur;
          if (err_r || sd_r == '0) begin
            z_r     <= '0;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_ZGO;
          end
        end
        S_ZGO: state_r <= S_ZWT;
        S_ZWT: begin
          if (div_done) begin
            if (d_r[wcs_pkg::DIFF_W-1]) begin
              z_r <= (zq > 46'(wcs_pkg::Z_NEG_MIN)) ? wcs_pkg::Z_NEG_MIN
                                                     : -zq[wcs_pkg::Z_W-1:0];
            end else begin
              z_r <= (zq > 46'(wcs_pkg::Z_POS_MAX)) ? wcs_pkg::Z_POS_MAX
                                                     : zq[wcs_pkg::Z_W-1:0];
            end
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (can_emit) begin
            out_z_r      <= z_r;
            out_center_r <= mean_r;
            out_spread_r <= sd_r;
            out_row_r    <= i_r[wcs_pkg::IDX_W-1:0];
            out_err_r    <= err_r;
            out_fin_r    <= last_row;
            if (last_row) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_ZRD;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/weighted_column_standardizer.sv */
`default_nettype none
// Channel  Direction  Signals
// in       input      in_valid/in_ready, in_sample, in_weight, in_last
// out      output     out_valid/out_ready, out_standardized .. out_final_res
// cfg      input      cfg_valid/cfg_ready, cfg_use_weights
//
// Loading accepts rows back to back while in_ready is high. The last row starts
// the back end: mean divide, variance pass, variance divide and square root, then
// per result a row read and a 46-step divide, skipped on error or zero spread.
// Input stalls from the last row until the last result is registered; a held-off
// output stalls the back end. Reset is synchronous; the row store needs no clear.
module weighted_column_standardizer #(
  parameter int MaxRows = wcs_pkg::DEF_MAX_ROWS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [wcs_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic [wcs_pkg::WEIGHT_W-1:0]        in_weight,
  input  wire logic                                in_last,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic                                cfg_use_weights,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [wcs_pkg::Z_W-1:0]           out_standardized,
  output logic signed [wcs_pkg::FIX_W-1:0]         out_center,
  output logic [wcs_pkg::FIX_W-1:0]                out_spread,
  output logic [wcs_pkg::IDX_W-1:0]                out_row_index,
  output logic                                     out_error,
  output logic                                     out_final_res
);

  localparam int AddrW = $clog2(MaxRows);

  logic               job_push, job_full, job_pop, job_empty, back_done;
  wcs_pkg::job_t      push_data, pop_data;
  logic [AddrW-1:0]   rd_addr;
  wcs_pkg::row_t      rd_row;

  wcs_front #(.MaxRows(MaxRows)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .in_weight       (in_weight),
    .in_last         (in_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_use_weights (cfg_use_weights),
    .rd_addr         (rd_addr),
    .rd_row          (rd_row),
    .job_push        (job_push),
    .job_data        (push_data),
    .job_full        (job_full),
    .back_done       (back_done)
  );

  wcs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_data),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (pop_data),
    .empty     (job_empty)
  );

  wcs_back #(.MaxRows(MaxRows)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_empty        (job_empty),
    .job_data         (pop_data),
    .job_pop          (job_pop),
    .rd_addr          (rd_addr),
    .rd_row           (rd_row),
    .back_done        (back_done),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_standardized (out_standardized),
    .out_center       (out_center),
    .out_spread       (out_spread),
    .out_row_index    (out_row_index),
    .out_error        (out_error),
    .out_final_res    (out_final_res)
  );

endmodule
`default_nettype wire

/* tb/weighted_column_standardizer_tb.sv */
`timescale 1ns / 1ps
module weighted_column_standardizer_tb;

  localparam int ROWS = wcs_pkg::DEF_MAX_ROWS;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [wcs_pkg::Z_W-1:0]   z;
    logic signed [wcs_pkg::FIX_W-1:0] center;
    logic [wcs_pkg::FIX_W-1:0]        spread;
    logic [wcs_pkg::IDX_W-1:0]        row;
    logic                             err;
    logic                             fin;
  } zscore_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, in_last;
  logic signed [wcs_pkg::SAMPLE_W-1:0] in_sample;
  logic [wcs_pkg::WEIGHT_W-1:0] in_weight;
  logic cfg_valid, cfg_ready, cfg_use_weights;
  logic out_valid, out_ready;
  logic signed [wcs_pkg::Z_W-1:0] out_standardized;
  logic signed [wcs_pkg::FIX_W-1:0] out_center;
  logic [wcs_pkg::FIX_W-1:0] out_spread;
  logic [wcs_pkg::IDX_W-1:0] out_row_index;
  logic out_error, out_final_res;

  // predictor state
  logic signed [wcs_pkg::SAMPLE_W-1:0] col_samples [ROWS];
  logic [wcs_pkg::WEIGHT_W-1:0] col_weights [ROWS];
  int unsigned col_rows;
  longint col_wsum;
  longint col_wtot;
  logic weights_on;

  zscore_t pending_z [$];
  int errors;
  longint cycles;
  int hold_req;
  int items_sent;

  weighted_column_standardizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample(in_sample), .in_weight(in_weight), .in_last(in_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_use_weights(cfg_use_weights),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_standardized(out_standardized), .out_center(out_center),
    .out_spread(out_spread), .out_row_index(out_row_index),
    .out_error(out_error), .out_final_res(out_final_res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] root64(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  function automatic void load_row(logic signed [15:0] x, logic [15:0] wt, logic lst);
    logic [15:0] w;
    logic [127:0] acc;
    logic [63:0] mag, var_q;
    longint mean, d, z;
    logic [31:0] sd;
    logic bad;
    zscore_t r;
    w = weights_on ? wt : 16'd1;
    if (col_rows < ROWS) begin
      col_samples[col_rows] = x;
      col_weights[col_rows] = w;
      col_wsum += longint'(x) * longint'(w);
      col_wtot += longint'(w);
      col_rows++;
    end
    if (!lst) return;
    mean = 0;
    sd = 0;
    bad = (col_wtot == 0);
    if (!bad) begin
      acc = 0;
      mean = (col_wsum * 65536) / col_wtot;
      for (int i = 0; i < col_rows; i++) begin
        d = longint'(col_samples[i]) * 65536 - mean;
        mag = (d < 0) ? -d : d;
        acc += 128'(col_weights[i]) * 128'(mag * mag);
      end
      var_q = 64'(acc / 128'(col_wtot));
      sd = root64(var_q);
    end
    for (int i = 0; i < col_rows; i++) begin
      z = 0;
      if (!bad && sd != 0) begin
        d = longint'(col_samples[i]) * 65536 - mean;
        z = (d * 4096) / longint'({32'd0, sd});
        if (z > 524287) z = 524287;
        if (z < -524288) z = -524288;
      end
      r.z = z[wcs_pkg::Z_W-1:0];
      r.center = bad ? '0 : mean[31:0];
      r.spread = bad ? '0 : sd;
      r.row = i[wcs_pkg::IDX_W-1:0];
      r.err = bad;
      r.fin = (i + 1 == col_rows);
      pending_z.push_back(r);
    end
    col_rows = 0;
    col_wsum = 0;
    col_wtot = 0;
  endfunction

  task automatic report(string field, int unsigned row, longint got, longint want);
    errors++;
    $display("mismatch %s row %0d: got %0d want %0d", field, row, got, want);
  endtask

  always @(posedge clk) begin
    zscore_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_z.size() == 0) begin
        report("unexpected", out_row_index, 0, 0);
      end else begin
        e = pending_z.pop_front();
        if (out_standardized !== e.z) report("standardized", e.row, out_standardized, e.z);
        if (out_center !== e.center) report("center", e.row, out_center, e.center);
        if (out_spread !== e.spread) report("spread", e.row, out_spread, e.spread);
        if (out_row_index !== e.row) report("row_index", e.row, out_row_index, e.row);
        if (out_error !== e.err) report("error", e.row, out_error, e.err);
        if (out_final_res !== e.fin) report("final_res", e.row, out_final_res, e.fin);
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    int idle_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
      idle_left = 0;
    end else if (hold_req > 0) begin
      out_ready <= 1'b0;
      hold_req--;
    end else if (idle_left > 0) begin
      out_ready <= 1'b0;
      idle_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) idle_left = gap_len();
    end
  end

  task automatic send_row(logic signed [15:0] x, logic [15:0] wt, logic lst, bit no_gap = 0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= x;
    in_weight <= wt;
    in_last <= lst;
    do @(posedge clk); while (!in_ready);
    load_row(x, wt, lst);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_z.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_weighting(logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_use_weights <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    weights_on = m;
  endtask

  task automatic test_extremes();
    send_row(-16'sd32768, 16'hFFFF, 1'b0);
    send_row(16'sd32767, 16'hFFFF, 1'b0);
    send_row(16'sd0, 16'd0, 1'b0);
    send_row(16'sd1, 16'd1, 1'b1);
    send_row(16'sd32767, 16'hFFFF, 1'b1);
    send_row(-16'sd32768, 16'd1, 1'b0);
    send_row(16'sd32767, 16'd1, 1'b1);
  endtask

  task automatic test_zero_weight();
    send_row(16'sd5, 16'd0, 1'b0);
    send_row(-16'sd7, 16'd0, 1'b1);
  endtask

  task automatic test_flat_column();
    for (int i = 0; i < 4; i++) send_row(-16'sd1234, 16'(i + 3), i == 3);
  endtask

  task automatic test_unweighted();
    set_weighting(1'b0);
    send_row(16'sd100, 16'd0, 1'b0);
    send_row(-16'sd32768, 16'hFFFF, 1'b0);
    send_row(16'sd32767, 16'd9, 1'b1);
    set_weighting(1'b1);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_column(int n, bit no_gap = 0);
    logic [15:0] w;
    for (int i = 0; i < n; i++) begin
      w = ($urandom_range(0, 9) == 0) ? 16'd0 : rand_field();
      send_row(rand_field(), w, i == n - 1, no_gap);
    end
  endtask

  task automatic test_random_columns();
    int n;
    while (items_sent < 320) begin
      if ($urandom_range(0, 9) == 0) set_weighting(1'($urandom_range(0, 1)));
      n = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
      send_column(n);
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_req = 3000;
    for (int c = 0; c < 3; c++) send_column(6, 1);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_weight = '0;
    in_last = 1'b0;
    cfg_valid = 1'b0;
    cfg_use_weights = 1'b1;
    weights_on = 1'b1;
    col_rows = 0;
    col_wsum = 0;
    col_wtot = 0;
    errors = 0;
    cycles = 0;
    hold_req = 0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_zero_weight();
    test_flat_column();
    test_unweighted();
    test_backpressure();
    test_random_columns();
    drain();
    if (errors == 0 && pending_z.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* weighted_column_standardizer.f */
hw/rtl/wcs_pkg.sv
hw/rtl/wcs_fifo.sv
hw/rtl/wcs_div.sv
hw/rtl/wcs_sqrt.sv
hw/rtl/wcs_front.sv
hw/rtl/wcs_back.sv
hw/rtl/weighted_column_standardizer.sv
tb/weighted_column_standardizer_tb.sv
